>>> src/lgr_pkg.sv
// Shared constants and codes for the linear gain ramp.
// No dependencies; imported by every module of the block.
package lgr_pkg;

  // Gain format: unsigned Q1.23, full level is 1.0
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 23;
  localparam logic [GAIN_W-1:0] GAIN_FULL = 24'h800000;

  // Ramp duration: unsigned Q8.16 seconds
  localparam int RAMP_W = 24;

  // Step numerator is 2^STEP_EXP; any divisor at or below SAT_DEN saturates the step
  localparam int STEP_EXP = 39;
  localparam longint unsigned SAT_DEN = 64'd1 << (STEP_EXP - GAIN_FRAC);

  // Default parameter values
  localparam int SAMPLE_RATE_DEF = 48000;
  localparam int SAMPLE_BITS_DEF = 24;

  // Input opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_UP     = 2'd1;
  localparam logic [1:0] OP_DOWN   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_MUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FULL  = 2'd1;

endpackage

>>> src/lgr_div.sv
// Ramp step unit: step = clamp(floor(2^39 / (rate * ramp)), 1, 1.0).
// Restoring divider, one quotient bit per cycle. Depends on lgr_pkg.
module lgr_div import lgr_pkg::*; #(
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAMP_W-1:0] ramp,
  output logic              done,
  output logic [GAIN_W-1:0] step
);

  localparam int RATE_W = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int DEN_W  = RATE_W + RAMP_W;
  localparam int CNT_W  = $clog2(GAIN_FRAC);
  localparam logic [RATE_W-1:0] RATE = RATE_W'(SAMPLE_RATE_HZ);
  localparam logic [DEN_W-1:0]  SAT  = DEN_W'(SAT_DEN);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER} div_state_t;

  div_state_t           state;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [GAIN_FRAC-1:0] quo;
  logic [CNT_W-1:0]     cnt;

  logic [DEN_W:0]       rem_sh;
  logic                 fits;
  logic [DEN_W-1:0]     rem_next;
  logic [GAIN_FRAC-1:0] quo_next;

  // One restoring step: shift in a zero dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem, 1'b0};
    fits     = (rem_sh >= {1'b0, den});
    rem_next = fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    quo_next = {quo[GAIN_FRAC-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            den   <= DEN_W'(RATE) * DEN_W'(ramp);
            state <= D_CHECK;
          end
        end
        // Small divisors (including zero) give a step of full scale
        D_CHECK: begin
          if (den <= SAT) begin
            step  <= GAIN_FULL;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            // Upper quotient bits are known zero; partial remainder starts at 2^16
            rem   <= SAT;
            quo   <= '0;
            cnt   <= CNT_W'(GAIN_FRAC - 1);
            state <= D_ITER;
          end
        end
        D_ITER: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            // Floor of a very long ramp is held at one LSB
            step  <= (quo_next == '0) ? GAIN_W'(1) : GAIN_W'(quo_next);
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> src/lgr_mul.sv
// Sample-by-gain multiplier, two gain bits (one radix-4 digit) per cycle.
// Gives floor(sample * gain / 2^23) truncated to SAMPLE_BITS. Depends on lgr_pkg.
module lgr_mul import lgr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [GAIN_W-1:0]      gain,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] product
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int DIGITS = GAIN_W / 2;
  localparam int CNT_W  = $clog2(DIGITS);

  logic                     busy;
  logic signed [PROD_W-1:0] mcand;
  logic        [PROD_W-1:0] acc;
  logic        [GAIN_W-1:0] mplier;
  logic        [CNT_W-1:0]  cnt;

  logic [PROD_W-1:0] add_lo;
  logic [PROD_W-1:0] add_hi;
  logic [PROD_W-1:0] acc_next;

  // Partial product for the current digit, accumulated modulo 2^PROD_W
  always_comb begin
    add_lo   = mplier[0] ? mcand : '0;
    add_hi   = mplier[1] ? PROD_W'(mcand <<< 1) : '0;
    acc_next = acc + add_lo + add_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          mcand  <= PROD_W'(sample);
          mplier <= gain;
          acc    <= '0;
          cnt    <= CNT_W'(DIGITS - 1);
          busy   <= 1'b1;
        end
      end else begin
        acc    <= acc_next;
        mcand  <= mcand <<< 2;
        mplier <= mplier >> 2;
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          // Arithmetic shift by the gain fraction, low bits kept
          product <= acc_next[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
          done    <= 1'b1;
          busy    <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/linear_gain_ramp.sv
// Top level of the linear gain ramp: control sequencer, gain state, config.
// Uses lgr_pkg, lgr_div (ramp step) and lgr_mul (sample scaling).

// Linear fade between silence and full level. A sample transaction (opcode 0)
// moves the Q1.23 gain one step toward its end point and returns the sample
// times the new gain, or zero with the gain unchanged while muted; trigger
// transactions (1 up, 2 down) only set the direction and return nothing.
// One transaction is in work at a time; the output register lets the next
// one be accepted while a result waits. A ramping sample passes through the
// divider (divisor load, check, then 23 quotient bits) and then the 12-digit
// multiplier; a ramp short enough to saturate the step ends the divider after
// its check; a sample already at its end point skips the divider; a muted
// sample skips both; a trigger is done when accepted. A stalled output holds
// the result in the push state. Writing start_full reloads the gain and
// direction at once.
module linear_gain_ramp import lgr_pkg::*; #(
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [RAMP_W-1:0]             ramp_seconds,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          reached_full,
  output logic                          reached_silent,
  // configuration
  input  logic                          write_en,
  input  logic [CFG_IDX_W-1:0]          write_index,
  input  logic                          write_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_PUSH} state_t;

  state_t                        state;
  logic                          bypass_mute;
  logic [GAIN_W-1:0]             gain;
  logic                          rising;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [SAMPLE_BITS-1:0] res;
  logic                          full_f;
  logic                          silent_f;

  logic                          in_take;
  logic                          at_end;
  logic                          div_start;
  logic                          div_done;
  logic [GAIN_W-1:0]             step;
  logic                          mul_start;
  logic                          mul_done;
  logic signed [SAMPLE_BITS-1:0] mul_product;
  logic [GAIN_W-1:0]             gain_next;
  logic [GAIN_W-1:0]             mul_gain;
  logic signed [SAMPLE_BITS-1:0] mul_sample;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Gain already parked at the end point of the current direction
  assign at_end = rising ? (gain == GAIN_FULL) : (gain == '0);

  assign div_start = in_take && (opcode == OP_SAMPLE) && !bypass_mute && !at_end;
  assign mul_start = (in_take && (opcode == OP_SAMPLE) && !bypass_mute && at_end)
                  || (state == S_DIV && div_done);

  // Step toward the end point with clamping
  always_comb begin
    if (rising) begin
      gain_next = (gain >= GAIN_FULL - step) ? GAIN_FULL : gain + step;
    end else begin
      gain_next = (gain <= step) ? '0 : gain - step;
    end
  end

  assign mul_gain   = (state == S_DIV) ? gain_next : gain;
  assign mul_sample = (state == S_IDLE) ? sample_in : samp;

  lgr_div #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .ramp (ramp_seconds),
    .done (div_done),
    .step (step)
  );

  lgr_mul #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .sample (mul_sample),
    .gain   (mul_gain),
    .done   (mul_done),
    .product(mul_product)
  );

  // Sequencer, gain state, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bypass_mute <= 1'b0;
      gain        <= GAIN_FULL;
      rising      <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (opcode)
              OP_UP:   rising <= 1'b1;
              OP_DOWN: rising <= 1'b0;
              OP_SAMPLE: begin
                samp     <= sample_in;
                full_f   <= 1'b0;
                silent_f <= 1'b0;
                if (bypass_mute) begin
                  res   <= '0;
                  state <= S_PUSH;
                end else if (at_end) begin
                  state <= S_MUL;
                end else begin
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain     <= gain_next;
            full_f   <= rising && (gain_next == GAIN_FULL);
            silent_f <= !rising && (gain_next == '0);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            res   <= mul_product;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            sample_out     <= res;
            reached_full   <= full_f;
            reached_silent <= silent_f;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // The user must write config only while idle; the block does not enforce it
      if (write_en) begin
        case (write_index)
          REG_BYPASS_MUTE: bypass_mute <= write_data;
          REG_START_FULL: begin
            rising <= write_data;
            gain   <= write_data ? GAIN_FULL : '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // Gain never leaves the range 0 to 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= GAIN_FULL)
    else $error("gain above full scale");

  // A result never claims both end points
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && reached_full && reached_silent))
    else $error("both end flags set");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide phase");

  // Multiplier finishes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier done outside multiply phase");
`endif

endmodule
